@@ sv/wsd_pkg.sv @@
`default_nettype none
package wsd_pkg;

  localparam int RpmW   = 16;
  localparam int SlipW  = 24;
  localparam int CfgW   = 24;
  localparam int IdxW   = 3;
  localparam int DvdW   = 24;
  localparam int ProdW  = 2 * RpmW;
  localparam int PctW   = 31;
  localparam int Div1Steps = 24;
  localparam int Div2Steps = 7;
  localparam int CntW   = 5;

  localparam logic [IdxW-1:0] REG_GPS_MODE  = 3'd0;
  localparam logic [IdxW-1:0] REG_TIRE_CIRC = 3'd1;
  localparam logic [IdxW-1:0] REG_LOW_SPEED = 3'd2;
  localparam logic [IdxW-1:0] REG_MIN_VEH   = 3'd3;
  localparam logic [IdxW-1:0] REG_SLIP_THR  = 3'd4;

  localparam logic [SlipW-1:0] SLIP_MAX  = 24'hFFFFFF;
  localparam logic [PctW-1:0]  SLIP_BIAS = 31'd25600;

  typedef struct packed {
    logic                load;
    logic                step;
    logic [RpmW-1:0]     rem;
    logic [DvdW-1:0]     dvd;
  } div_ctrl_t;

endpackage
`default_nettype wire

@@ sv/wsd_div.sv @@
`default_nettype none
module wsd_div (
  input  wire logic                    clk,
  input  wire wsd_pkg::div_ctrl_t      ctrl,
  input  wire logic [wsd_pkg::RpmW-1:0] divisor,
  output logic [wsd_pkg::RpmW-1:0]     rem,
  output logic [wsd_pkg::DvdW-1:0]     quo
);
  import wsd_pkg::*;

  logic [RpmW:0] shifted;
  logic [RpmW:0] trial;
  logic          fits;

  assign shifted = {rem, quo[DvdW-1]};
  assign trial   = shifted - {1'b0, divisor};
  assign fits    = shifted >= {1'b0, divisor};

  // restoring division, one quotient bit per step
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= ctrl.rem;
      quo <= ctrl.dvd;
    end else if (ctrl.step) begin
      rem <= fits ? trial[RpmW-1:0] : shifted[RpmW-1:0];
      quo <= {quo[DvdW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

@@ sv/wsd_speed.sv @@
`default_nettype none
module wsd_speed (
  input  wire logic                     clk,
  input  wire logic                     capture,
  input  wire logic [wsd_pkg::RpmW-1:0] tire_circumference,
  input  wire logic [wsd_pkg::RpmW-1:0] sensor_one_rpm,
  input  wire logic                     gps_fix,
  input  wire logic [wsd_pkg::RpmW-1:0] ground_speed,
  input  wire logic                     gps_mode,
  input  wire logic [wsd_pkg::RpmW-1:0] low_speed_threshold,
  output logic                          low_speed
);
  import wsd_pkg::*;

  logic [ProdW-1:0] prod;
  logic             fix;
  logic [RpmW-1:0]  speed;
  logic [ProdW-1:0] limit;

  always_ff @(posedge clk) begin
    if (capture) begin
      prod  <= tire_circumference * sensor_one_rpm;
      fix   <= gps_fix;
      speed <= ground_speed;
    end
  end

  // threshold times 1056 = times 1024 plus times 32
  assign limit = ({{(ProdW-RpmW){1'b0}}, low_speed_threshold} << 10)
               + ({{(ProdW-RpmW){1'b0}}, low_speed_threshold} << 5);

  assign low_speed = gps_mode ? (fix && (speed < low_speed_threshold)) : (prod < limit);

endmodule
`default_nettype wire

@@ sv/wheel_slip_detector_top.sv @@
`default_nettype none
// One request is processed at a time; in_ready is high only when idle.
// A shared compare-subtract divider runs 24 steps for the speed ratio,
// then 7 steps for the slip fraction.
// Reset (synchronous, active high) clears config, held state and handshakes.
// The output register holds a result until taken; the next request may enter.
module wheel_slip_detector_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [wsd_pkg::IdxW-1:0]  cfg_index,
  input  wire logic [wsd_pkg::CfgW-1:0]  cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [wsd_pkg::RpmW-1:0]  engine_rpm,
  input  wire logic [wsd_pkg::RpmW-1:0]  sensor_one_rpm,
  input  wire logic [wsd_pkg::RpmW-1:0]  sensor_two_rpm,
  input  wire logic                      gps_fix,
  input  wire logic [wsd_pkg::RpmW-1:0]  ground_speed,
  input  wire logic [wsd_pkg::RpmW-1:0]  gps_rpm,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           slip_drive,
  output logic                           low_speed_drive,
  output logic [wsd_pkg::SlipW-1:0]      slip_percent,
  output logic [wsd_pkg::SlipW-1:0]      speed_ratio
);
  import wsd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIV1 = 3'd2;
  localparam logic [2:0] ST_MID  = 3'd3;
  localparam logic [2:0] ST_DIV2 = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic              gps_mode;
  logic [RpmW-1:0]   tire_circumference;
  logic [RpmW-1:0]   low_speed_threshold;
  logic [RpmW-1:0]   min_vehicle_rpm;
  logic [SlipW-1:0]  slip_threshold;

  logic [RpmW-1:0]   held_tire_rpm;
  logic [RpmW-1:0]   held_vehicle_rpm;
  logic [SlipW-1:0]  held_slip;

  logic [2:0]        state;
  logic [CntW-1:0]   cnt;
  logic              upd;
  logic [DvdW-1:0]   q1;
  logic [PctW-1:0]   p1;

  logic              accept;
  logic              out_free;
  logic [RpmW-1:0]   tire_new;
  logic [RpmW-1:0]   veh_sel;
  logic [RpmW-1:0]   veh_new;
  div_ctrl_t         div_ctrl;
  logic [RpmW-1:0]   div_rem;
  logic [DvdW-1:0]   div_quo;
  logic [RpmW+6:0]   rem100;
  logic [PctW-1:0]   q100;
  logic [PctW-1:0]   slip_sum;
  logic [SlipW-1:0]  slip_sat;
  logic [SlipW-1:0]  slip_new;
  logic              low_speed;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  assign tire_new = (engine_rpm > sensor_two_rpm) ? engine_rpm : sensor_two_rpm;
  assign veh_sel  = gps_mode ? gps_rpm : sensor_one_rpm;
  assign veh_new  = (veh_sel > min_vehicle_rpm) ? veh_sel : min_vehicle_rpm;

  assign rem100 = ({7'd0, div_rem} << 6) + ({7'd0, div_rem} << 5) + ({7'd0, div_rem} << 2);
  assign q100   = ({7'd0, div_quo} << 6) + ({7'd0, div_quo} << 5) + ({7'd0, div_quo} << 2);

  assign slip_sum = p1 + {{(PctW-7){1'b0}}, div_quo[6:0]} - SLIP_BIAS;
  assign slip_sat = (slip_sum > {{(PctW-SlipW){1'b0}}, SLIP_MAX}) ? SLIP_MAX
                                                                  : slip_sum[SlipW-1:0];

  always_comb begin
    if (!(held_vehicle_rpm < held_tire_rpm)) begin
      slip_new = '0;
    end else if (held_vehicle_rpm == '0) begin
      slip_new = SLIP_MAX;
    end else begin
      slip_new = slip_sat;
    end
  end

  always_comb begin
    div_ctrl      = '0;
    div_ctrl.step = (state == ST_DIV1) || (state == ST_DIV2);
    if (state == ST_PREP) begin
      div_ctrl.load = 1'b1;
      div_ctrl.dvd  = {held_tire_rpm, 8'd0};
    end else if (state == ST_MID) begin
      div_ctrl.load = 1'b1;
      div_ctrl.rem  = rem100[RpmW+6:7];
      div_ctrl.dvd  = {rem100[6:0], {(DvdW-7){1'b0}}};
    end
  end

  wsd_div u_div (
    .clk     (clk),
    .ctrl    (div_ctrl),
    .divisor (held_vehicle_rpm),
    .rem     (div_rem),
    .quo     (div_quo)
  );

  wsd_speed u_speed (
    .clk                 (clk),
    .capture             (accept),
    .tire_circumference  (tire_circumference),
    .sensor_one_rpm      (sensor_one_rpm),
    .gps_fix             (gps_fix),
    .ground_speed        (ground_speed),
    .gps_mode            (gps_mode),
    .low_speed_threshold (low_speed_threshold),
    .low_speed           (low_speed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gps_mode            <= 1'b0;
      tire_circumference  <= '0;
      low_speed_threshold <= '0;
      min_vehicle_rpm     <= '0;
      slip_threshold      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GPS_MODE:  gps_mode            <= cfg_data[0];
        REG_TIRE_CIRC: tire_circumference  <= cfg_data[RpmW-1:0];
        REG_LOW_SPEED: low_speed_threshold <= cfg_data[RpmW-1:0];
        REG_MIN_VEH:   min_vehicle_rpm     <= cfg_data[RpmW-1:0];
        REG_SLIP_THR:  slip_threshold      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      cnt              <= '0;
      upd              <= 1'b0;
      held_tire_rpm    <= '0;
      held_vehicle_rpm <= '0;
      held_slip        <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            held_tire_rpm <= tire_new;
            upd           <= !gps_mode || gps_fix;
            if (!gps_mode || gps_fix) begin
              held_vehicle_rpm <= veh_new;
            end
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          cnt   <= '0;
          state <= ST_DIV1;
        end
        ST_DIV1: begin
          cnt <= cnt + 1'b1;
          if (cnt == CntW'(Div1Steps - 1)) begin
            state <= ST_MID;
          end
        end
        ST_MID: begin
          q1    <= div_quo;
          p1    <= q100;
          cnt   <= '0;
          state <= ST_DIV2;
        end
        ST_DIV2: begin
          cnt <= cnt + 1'b1;
          if (cnt == CntW'(Div2Steps - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            low_speed_drive <= low_speed;
            speed_ratio     <= (held_vehicle_rpm == '0) ? '0 : q1;
            if (upd) begin
              held_slip    <= slip_new;
              slip_percent <= slip_new;
              slip_drive   <= slip_new > slip_threshold;
            end else begin
              slip_percent <= held_slip;
              slip_drive   <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
